@@ rtl/core/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// qau_pkg
// Types, constants and the term table of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 13;
  localparam int OW = (DATA_WIDTH + 1 > FRAC_BITS + 2) ? DATA_WIDTH + 1 : FRAC_BITS + 2;
  localparam int PW = 2 * OW;
  localparam int SW = PW + 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [OW-1:0]         opnd_t;
  typedef logic signed [PW-1:0]         prod_t;
  typedef logic signed [SW-1:0]         sum_t;
  typedef logic [3:0]                   cls_t;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_MUL   = 3'd2;
  localparam logic [2:0] OP_CONJ  = 3'd3;
  localparam logic [2:0] OP_NEG   = 3'd4;
  localparam logic [2:0] OP_SCALE = 3'd5;
  localparam logic [2:0] OP_ROT   = 3'd6;
  localparam logic [2:0] OP_MAT   = 3'd7;

  localparam cls_t CLS_ADD   = 4'd0;
  localparam cls_t CLS_SUB   = 4'd1;
  localparam cls_t CLS_MUL   = 4'd2;
  localparam cls_t CLS_CONJ  = 4'd3;
  localparam cls_t CLS_NEG   = 4'd4;
  localparam cls_t CLS_SCALE = 4'd5;
  localparam cls_t CLS_ROT   = 4'd6;
  localparam cls_t CLS_MAT0  = 4'd7;
  localparam cls_t CLS_MAT1  = 4'd8;
  localparam cls_t CLS_MAT2  = 4'd9;

  localparam logic [3:0] RI_ONE  = 4'd8;
  localparam logic [3:0] RI_ZERO = 4'd9;
  localparam int         NRHS    = 10;

  localparam opnd_t ONE = opnd_t'(1) <<< FRAC_BITS;

  typedef struct packed {
    logic [2:0] req_type;
    data_t      a_w;
    data_t      a_x;
    data_t      a_y;
    data_t      a_z;
    data_t      b_w;
    data_t      b_x;
    data_t      b_y;
    data_t      b_z;
  } req_t;

  typedef struct packed {
    data_t res_w;
    data_t res_x;
    data_t res_y;
    data_t res_z;
    logic  last_row;
    logic  saturated;
  } res_t;

  typedef struct packed {
    logic            rot;
    logic            last;
    logic            sat;
    data_t [3:0]     a;
  } side_t;

  typedef struct packed {
    logic       en;
    logic       neg;
    logic       dbl;
    logic [2:0] li;
    logic [3:0] ri;
  } term_t;

  // Term t of result element k: left operand index into {a, b}, right operand
  // index into {a, b, one, zero}, and a coefficient of 0, +-1 or +-2.
  function automatic term_t get_term(input cls_t cls, input logic [1:0] k,
                                     input logic [1:0] t);
    term_t      r;
    logic       hneg;
    logic [1:0] m;
    logic [1:0] lo;
    logic [1:0] hi;
    logic [1:0] mn;
    r    = '0;
    hneg = (k == 2'd0) ? (t != 2'd0) : (k == 2'd1) ? (t == 2'd3) :
           (k == 2'd2) ? (t == 2'd1) : (t == 2'd2);
    m    = 2'(cls - CLS_MAT0);
    lo   = (m < k) ? m : k;
    hi   = (m < k) ? k : m;
    mn   = (m == 2'd2) ? 2'd0 : 2'(m + 2'd1);
    unique case (cls)
      CLS_ADD, CLS_SUB: begin
        if (t == 2'd0) begin
          r.en = 1'b1;
          r.li = {1'b0, k};
          r.ri = RI_ONE;
        end else if (t == 2'd1) begin
          r.en  = 1'b1;
          r.neg = (cls == CLS_SUB);
          r.li  = {1'b1, k};
          r.ri  = RI_ONE;
        end
      end
      CLS_CONJ, CLS_NEG: begin
        if (t == 2'd0) begin
          r.en  = 1'b1;
          r.neg = (cls == CLS_NEG) || (k != 2'd0);
          r.li  = {1'b0, k};
          r.ri  = RI_ONE;
        end
      end
      CLS_SCALE: begin
        if (t == 2'd0) begin
          r.en = 1'b1;
          r.li = {1'b0, k};
          r.ri = 4'd4;
        end
      end
      CLS_MUL, CLS_ROT: begin
        r.en  = 1'b1;
        r.neg = hneg;
        r.li  = {1'b0, t};
        r.ri  = ((cls == CLS_ROT) && ((k ^ t) == 2'd0)) ? RI_ZERO : {2'b01, k ^ t};
      end
      CLS_MAT0, CLS_MAT1, CLS_MAT2: begin
        if (k == 2'd3) begin
          r.en = 1'b0;
        end else if (k == m) begin
          r.en  = 1'b1;
          r.neg = !((t == 2'd0) || (t == 2'(m + 2'd1)));
          r.li  = {1'b0, t};
          r.ri  = {2'b00, t};
        end else if (t == 2'd0) begin
          r.en  = 1'b1;
          r.dbl = 1'b1;
          r.li  = 3'(lo) + 3'd1;
          r.ri  = 4'(hi) + 4'd1;
        end else if (t == 2'd1) begin
          r.en  = 1'b1;
          r.dbl = 1'b1;
          r.neg = (k == mn);
          r.li  = 3'd0;
          r.ri  = 4'd4 - 4'(m) - 4'(k);
        end
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/qau_seq.sv @@
// ----------------------------------------------------------------------------
// qau_seq
// Request register; issues the three rows of a matrix request in turn.
// ----------------------------------------------------------------------------
module qau_seq import qau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output cls_t cls_o,
  output logic last_o,
  output req_t req_o
);

  logic       valid_q, valid_d;
  logic [1:0] row_q, row_d;
  req_t       req_q;
  logic       take;

  assign busy_o = valid_q && (req_q.req_type == OP_MAT) && (row_q != 2'd2);
  assign take   = start_i && !busy_o;

  always_comb begin
    valid_d = valid_q;
    row_d   = row_q;
    if (take) begin
      valid_d = 1'b1;
      row_d   = 2'd0;
    end else if (busy_o) begin
      row_d = row_q + 2'd1;
    end else begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      row_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      row_q   <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= req_i;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_t'(req_q.req_type) + cls_t'(row_q);
  assign last_o  = (req_q.req_type != OP_MAT) || (row_q == 2'd2);
  assign req_o   = req_q;

endmodule

@@ rtl/core/qau_mac.sv @@
// ----------------------------------------------------------------------------
// qau_mac
// Three-stage sum of products: multiply, accumulate, shift and saturate.
// ----------------------------------------------------------------------------
module qau_mac import qau_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  cls_t  cls_i,
  input  opnd_t lhs_i [8],
  input  opnd_t rhs_i [NRHS],
  input  side_t side_i,
  output logic  valid_o,
  output data_t res_o [4],
  output logic  sat_o,
  output side_t side_o
);

  localparam sum_t MAX_S = sum_t'({(DATA_WIDTH-1){1'b1}});
  localparam sum_t MIN_S = ~MAX_S;

  logic  [2:0] valid_q;
  side_t       side1_q, side2_q, side3_q;
  prod_t       prod_q [4][4];
  term_t       term_q [4][4];
  sum_t        sum_q  [4];
  data_t       res_q  [4];
  logic  [3:0] sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    term_t tm;
    for (int k = 0; k < 4; k++) begin
      for (int t = 0; t < 4; t++) begin
        tm           = get_term(cls_i, 2'(k), 2'(t));
        term_q[k][t] <= tm;
        prod_q[k][t] <= lhs_i[tm.li] * rhs_i[tm.ri];
      end
    end
    side1_q <= side_i;
  end

  always_ff @(posedge clk_i) begin
    sum_t acc;
    sum_t p;
    for (int k = 0; k < 4; k++) begin
      acc = '0;
      for (int t = 0; t < 4; t++) begin
        p = sum_t'(prod_q[k][t]);
        if (term_q[k][t].dbl) p = p <<< 1;
        if (term_q[k][t].neg) p = -p;
        if (term_q[k][t].en) acc = acc + p;
      end
      sum_q[k] <= acc;
    end
    side2_q <= side1_q;
  end

  always_ff @(posedge clk_i) begin
    sum_t sh;
    for (int k = 0; k < 4; k++) begin
      sh = sum_q[k] >>> FRAC_BITS;
      if (sh > MAX_S) begin
        res_q[k] <= data_t'(MAX_S);
        sat_q[k] <= 1'b1;
      end else if (sh < MIN_S) begin
        res_q[k] <= data_t'(MIN_S);
        sat_q[k] <= 1'b1;
      end else begin
        res_q[k] <= data_t'(sh);
        sat_q[k] <= 1'b0;
      end
    end
    side3_q <= side2_q;
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;
  assign sat_o   = |sat_q;
  assign side_o  = side3_q;

endmodule

@@ rtl/core/quaternion_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Pipelined quaternion add, subtract, product, conjugate, negate, scale,
// rotation and rotation matrix in signed fixed point.
// ----------------------------------------------------------------------------
// A request is transferred at a rising edge where start_i is high and busy_o
// is low. Results appear on res_o for one cycle with valid_o high; the
// receiver cannot hold them off. Every request yields one result, except a
// matrix request, which yields three rows on consecutive cycles, the last
// marked by last_row.
// From the transfer edge to the first result a request passes through one
// request register, then two passes of a three-stage sum-of-products unit
// (multiply, accumulate, shift and saturate). The second pass forms the
// conjugate product of a rotation and is an exact identity for the others.
// A new request is taken every cycle while busy_o is low; after a matrix
// request busy_o stays high while its remaining rows are issued, so each of
// its three rows takes its own slot in the pipeline.
// Reset clears all valid bits; no result leaves the block until a request
// has passed through the pipeline.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic valid_o,
  output res_t res_o
);

  logic  s_valid;
  cls_t  s_cls;
  logic  s_last;
  req_t  s_req;

  opnd_t lhs1 [8];
  opnd_t rhs1 [NRHS];
  side_t side1;
  logic  v1;
  data_t r1 [4];
  logic  sat1;
  side_t side1_o;

  opnd_t lhs2 [8];
  opnd_t rhs2 [NRHS];
  side_t side2;
  logic  v2;
  data_t r2 [4];
  logic  sat2;
  side_t side2_o;

  qau_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .valid_o (s_valid),
    .cls_o   (s_cls),
    .last_o  (s_last),
    .req_o   (s_req)
  );

  always_comb begin
    lhs1[0] = opnd_t'(s_req.a_w);
    lhs1[1] = opnd_t'(s_req.a_x);
    lhs1[2] = opnd_t'(s_req.a_y);
    lhs1[3] = opnd_t'(s_req.a_z);
    lhs1[4] = opnd_t'(s_req.b_w);
    lhs1[5] = opnd_t'(s_req.b_x);
    lhs1[6] = opnd_t'(s_req.b_y);
    lhs1[7] = opnd_t'(s_req.b_z);
    for (int i = 0; i < 8; i++) rhs1[i] = lhs1[i];
    rhs1[RI_ONE]  = ONE;
    rhs1[RI_ZERO] = '0;
    side1.rot  = (s_cls == CLS_ROT);
    side1.last = s_last;
    side1.sat  = 1'b0;
    side1.a    = {s_req.a_z, s_req.a_y, s_req.a_x, s_req.a_w};
  end

  qau_mac u_pass1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .cls_i   (s_cls),
    .lhs_i   (lhs1),
    .rhs_i   (rhs1),
    .side_i  (side1),
    .valid_o (v1),
    .res_o   (r1),
    .sat_o   (sat1),
    .side_o  (side1_o)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) lhs2[i] = '0;
    for (int i = 0; i < NRHS; i++) rhs2[i] = '0;
    for (int i = 0; i < 4; i++) lhs2[i] = opnd_t'(r1[i]);
    if (side1_o.rot) begin
      rhs2[4] = opnd_t'(side1_o.a[0]);
      rhs2[5] = -opnd_t'(side1_o.a[1]);
      rhs2[6] = -opnd_t'(side1_o.a[2]);
      rhs2[7] = -opnd_t'(side1_o.a[3]);
    end else begin
      rhs2[4] = ONE;
    end
    side2     = side1_o;
    side2.sat = sat1;
  end

  qau_mac u_pass2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .cls_i   (CLS_MUL),
    .lhs_i   (lhs2),
    .rhs_i   (rhs2),
    .side_i  (side2),
    .valid_o (v2),
    .res_o   (r2),
    .sat_o   (sat2),
    .side_o  (side2_o)
  );

  assign valid_o         = v2;
  assign res_o.res_w     = side2_o.rot ? '0 : r2[0];
  assign res_o.res_x     = r2[1];
  assign res_o.res_y     = r2[2];
  assign res_o.res_z     = r2[3];
  assign res_o.last_row  = side2_o.last;
  assign res_o.saturated = sat2 || side2_o.sat;

endmodule

@@ rtl/core/qau_checker.sv @@
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of request sequencing and result timing.
// ----------------------------------------------------------------------------
module qau_checker import qau_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic valid_o,
  input res_t res_o
);

  logic take;
  assign take = start_i && !busy_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o ##1 busy_o |=> !busy_o)
    else $error("busy held longer than a matrix request needs");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_i.req_type == OP_MAT) |=> busy_o ##1 busy_o)
    else $error("matrix request did not hold off the next transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_i.req_type != OP_MAT) |=> !busy_o)
    else $error("single-result request raised busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_i.req_type != OP_MAT) |-> ##7 (valid_o && res_o.last_row))
    else $error("single result missing or not marked last");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (req_i.req_type == OP_MAT) |-> ##7 (valid_o && !res_o.last_row && res_o.res_z == '0)
      ##1 (valid_o && !res_o.last_row) ##1 (valid_o && res_o.last_row))
    else $error("matrix rows out of order");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .req_i   (req_i),
  .busy_o  (busy_o),
  .valid_o (valid_o),
  .res_o   (res_o)
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the quaternion arithmetic unit. A directed table
// covers every operation and the saturation corners, then random requests
// follow. Each request's results are computed by a local fixed-point
// predictor and compared, in order, with the rows the block returns.
// ----------------------------------------------------------------------------
module tb_top;
  import qau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [15:0] MAXV = 16'sh7fff;
  localparam logic signed [15:0] MINV = -16'sh8000;
  localparam logic signed [15:0] UNIT = 16'sh2000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic valid_o;
  res_t res_o;

  res_t expected_rows[$];
  int   mismatches;
  bit   gaps_on;

  quaternion_arithmetic_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .valid_o(valid_o), .res_o(res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // Shift right by the fraction bits (if asked) and clip to 16 bits.
  function automatic logic signed [15:0] clip(input logic signed [63:0] acc,
                                              input bit shift, inout bit sat);
    logic signed [63:0] v;
    v = shift ? (acc >>> FRAC_BITS) : acc;
    if (v > 64'sd32767) begin
      sat = 1'b1;
      return MAXV;
    end
    if (v < -64'sd32768) begin
      sat = 1'b1;
      return MINV;
    end
    return v[15:0];
  endfunction

  function automatic void hamilton(input logic signed [63:0] u[4],
                                   input logic signed [63:0] v[4],
                                   output logic signed [63:0] r[4], inout bit sat);
    r[0] = clip(u[0]*v[0] - u[1]*v[1] - u[2]*v[2] - u[3]*v[3], 1, sat);
    r[1] = clip(u[0]*v[1] + u[1]*v[0] + u[2]*v[3] - u[3]*v[2], 1, sat);
    r[2] = clip(u[0]*v[2] - u[1]*v[3] + u[2]*v[0] + u[3]*v[1], 1, sat);
    r[3] = clip(u[0]*v[3] + u[1]*v[2] - u[2]*v[1] + u[3]*v[0], 1, sat);
  endfunction

  function automatic res_t pack_row(input logic signed [63:0] r[4], input bit last,
                                    input bit sat);
    res_t o;
    o.res_w = r[0][15:0];
    o.res_x = r[1][15:0];
    o.res_y = r[2][15:0];
    o.res_z = r[3][15:0];
    o.last_row = last;
    o.saturated = sat;
    return o;
  endfunction

  task automatic predict_results(input req_t q);
    logic signed [63:0] a[4], b[4], r[4], t[4], c[4];
    bit sat;
    a = '{q.a_w, q.a_x, q.a_y, q.a_z};
    b = '{q.b_w, q.b_x, q.b_y, q.b_z};
    sat = 0;
    case (q.req_type)
      OP_MAT: begin
        sat = 0;
        r[0] = clip(a[0]*a[0] + a[1]*a[1] - a[2]*a[2] - a[3]*a[3], 1, sat);
        r[1] = clip(2*a[1]*a[2] - 2*a[0]*a[3], 1, sat);
        r[2] = clip(2*a[1]*a[3] + 2*a[0]*a[2], 1, sat);
        r[3] = 0;
        expected_rows.push_back(pack_row(r, 0, sat));
        sat = 0;
        r[0] = clip(2*a[1]*a[2] + 2*a[0]*a[3], 1, sat);
        r[1] = clip(a[0]*a[0] - a[1]*a[1] + a[2]*a[2] - a[3]*a[3], 1, sat);
        r[2] = clip(2*a[2]*a[3] - 2*a[0]*a[1], 1, sat);
        expected_rows.push_back(pack_row(r, 0, sat));
        sat = 0;
        r[0] = clip(2*a[1]*a[3] - 2*a[0]*a[2], 1, sat);
        r[1] = clip(2*a[2]*a[3] + 2*a[0]*a[1], 1, sat);
        r[2] = clip(a[0]*a[0] - a[1]*a[1] - a[2]*a[2] + a[3]*a[3], 1, sat);
        expected_rows.push_back(pack_row(r, 1, sat));
        return;
      end
      OP_MUL: hamilton(a, b, r, sat);
      OP_ROT: begin
        c = '{0, b[1], b[2], b[3]};
        hamilton(a, c, t, sat);
        c = '{a[0], -a[1], -a[2], -a[3]};
        hamilton(t, c, r, sat);
        r[0] = 0;
      end
      default: begin
        for (int j = 0; j < 4; j++) begin
          case (q.req_type)
            OP_ADD:  r[j] = clip(a[j] + b[j], 0, sat);
            OP_SUB:  r[j] = clip(a[j] - b[j], 0, sat);
            OP_CONJ: r[j] = clip(j == 0 ? a[j] : -a[j], 0, sat);
            OP_NEG:  r[j] = clip(-a[j], 0, sat);
            default: r[j] = clip(a[j] * b[0], 1, sat);
          endcase
        end
      end
    endcase
    expected_rows.push_back(pack_row(r, 1, sat));
  endtask

  // Result checker: the receiver never stalls, so every strobe is a transfer.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && valid_o) begin
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", res_o);
      end else begin
        want = expected_rows.pop_front();
        if (res_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected w=%h x=%h y=%h z=%h l=%b s=%b, got %h %h %h %h %b %b",
                     want.res_w, want.res_x, want.res_y, want.res_z, want.last_row,
                     want.saturated, res_o.res_w, res_o.res_x, res_o.res_y, res_o.res_z,
                     res_o.last_row, res_o.saturated);
        end
      end
    end
  end

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(0, 5))
      0: return MAXV;
      1: return MINV;
      2: return 16'($urandom_range(0, 2*UNIT)) - UNIT;
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one request and hold it until the transfer edge.
  task automatic send_request(input req_t q);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 13) begin
        start_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    start_i <= 1'b1;
    req_i <= q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_results(q);
  endtask

  req_t table_req[$];
  res_t table_res[$];
  bit   table_known[$];

  task automatic add_row(input logic [2:0] op, input logic signed [15:0] aw, ax, ay, az,
                         bw, bx, by, bz);
    req_t q;
    q = '{op, aw, ax, ay, az, bw, bx, by, bz};
    table_req.push_back(q);
    table_known.push_back(0);
    table_res.push_back('0);
  endtask

  task automatic add_known(input logic [2:0] op, input logic signed [15:0] aw, ax, ay, az,
                           bw, bx, by, bz, input res_t want);
    add_row(op, aw, ax, ay, az, bw, bx, by, bz);
    table_known[$] = 1;
    table_res[$] = want;
  endtask

  initial begin
    req_t q;
    int   guard;
    res_t head;
    mismatches = 0;
    gaps_on = 1;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_known(OP_ADD, MAXV, MINV, 1, -1, 1, -1, -2, 2, '{MAXV, MINV, -1, 1, 1, 1});
    add_known(OP_SUB, MINV, MAXV, 0, 5, 1, -1, 0, 5, '{MINV, MAXV, 0, 0, 1, 1});
    add_known(OP_NEG, MINV, MAXV, 0, 1, 0, 0, 0, 0, '{MAXV, -MAXV, 0, -1, 1, 1});
    add_known(OP_CONJ, MINV, MINV, 3, MAXV, 0, 0, 0, 0, '{MINV, MAXV, -3, -MAXV, 1, 1});
    add_known(OP_SCALE, UNIT, -UNIT, 7, MAXV, UNIT, 0, 0, 0, '{UNIT, -UNIT, 7, MAXV, 1, 0});
    add_known(OP_MUL, UNIT, 0, 0, 0, UNIT, UNIT, -UNIT, 4, '{UNIT, UNIT, -UNIT, 4, 1, 0});
    add_row(OP_MUL, MAXV, MAXV, MINV, MINV, MINV, MAXV, MAXV, MINV);
    add_row(OP_MUL, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
    add_row(OP_SCALE, MINV, MAXV, -1, 1, MINV, 0, 0, 0);
    add_row(OP_SCALE, -1, -3, 5, -8193, 1, 0, 0, 0);
    add_row(OP_ROT, UNIT, 0, 0, 0, 0, 100, -200, 300);
    add_row(OP_ROT, 5793, 0, 0, 5793, 0, UNIT, 0, 0);
    add_row(OP_ROT, MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV, MINV);
    add_row(OP_MAT, UNIT, 0, 0, 0, 0, 0, 0, 0);
    add_row(OP_MAT, MINV, MINV, MINV, MINV, 0, 0, 0, 0);
    add_row(OP_MAT, MAXV, MINV, MAXV, -1, MAXV, MAXV, MAXV, MAXV);
    add_row(OP_MAT, 4096, -4096, 4096, 4096, 0, 0, 0, 0);
    add_row(OP_ADD, -1, -1, -1, -1, -1, -1, -1, -1);

    for (int i = 0; i < table_req.size(); i++) begin
      send_request(table_req[i]);
      if (table_known[i]) begin
        // A typed-in row replaces the predictor's entry for that request.
        head = expected_rows.pop_back();
        if (head !== table_res[i]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("predictor disagrees with table row %0d: %h vs %h", i, head,
                     table_res[i]);
        end
        expected_rows.push_back(table_res[i]);
      end
    end

    // Let everything drain before the random part.
    start_i <= 1'b0;
    guard = 0;
    while (expected_rows.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end

    for (int i = 0; i < 92; i++) begin
      gaps_on = !(i >= 40 && i < 70);
      q.req_type = 3'($urandom_range(0, 7));
      q.a_w = rand_elem(); q.a_x = rand_elem(); q.a_y = rand_elem(); q.a_z = rand_elem();
      q.b_w = rand_elem(); q.b_x = rand_elem(); q.b_y = rand_elem(); q.b_z = rand_elem();
      send_request(q);
    end
    start_i <= 1'b0;

    guard = 0;
    while (expected_rows.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && expected_rows.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/qau_pkg.sv
rtl/core/qau_seq.sv
rtl/core/qau_mac.sv
rtl/core/quaternion_arithmetic_unit.sv
rtl/core/qau_checker.sv
tb/tb_top.sv
